FILE: src/eov_pkg.sv
// eov_pkg: shared widths and command codes for the encoder odometry block.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package eov_pkg;

    localparam int RAW_W       = 16;  // raw encoder count width
    localparam int ANGLE_W     = 16;  // angle / velocity word width
    localparam int POS_W       = 32;  // accumulated position width
    localparam int VEL_W       = 16;  // filtered velocity width
    localparam int RES_W       = 15;  // resolution register width
    localparam int HIST_DEPTH_DEF = 20;

    localparam logic [RES_W-1:0] RES_RESET = RES_W'(1);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_RESET  = 1'b1
    } t_cmd;

endpackage

FILE: src/eov_if.sv
// eov_if: valid/ready channel interfaces for samples, results and config writes.
// Depends on eov_pkg for field widths.
`timescale 1ns / 1ps

interface eov_sample_if
    import eov_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             command;
    logic [RAW_W-1:0] raw_count;

    modport source (output valid, command, raw_count, input ready);
    modport sink   (input valid, command, raw_count, output ready);
endinterface

interface eov_result_if
    import eov_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;

    modport source (output valid, position, velocity, input ready);
    modport sink   (input valid, position, velocity, output ready);
endinterface

interface eov_cfg_if
    import eov_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: src/encoder_odometry_velocity.sv
// encoder_odometry_velocity: encoder count to position and filtered velocity.
// Depends on eov_pkg and the channel interfaces in eov_if.sv.
`timescale 1ns / 1ps
//
//  channel    dir  modport  payload
//  ---------  ---  -------  -------------------------------------------
//  i_sample   in   sink     command (1), raw_count (16)
//  o_result   out  source   position (32, signed), velocity (16, signed)
//  i_cfg      in   sink     data: resolution (15), always ready
//
//  From its transfer to o_result.valid a sample passes through the radix-4
//  restoring divider (2 quotient bits per cycle over the 32-bit dividend),
//  then the position update and history write, then the velocity filter,
//  and into the output register. A reset command goes through S_RST to it.
//  One item is in flight; the next is taken while a result still waits in
//  the output register, and the final stage holds while that register is
//  full. Reset (i_rst_n low, synchronous) clears all odometry state, the
//  history valid bits and resolution (to 1); no clearing pass is needed.

module encoder_odometry_velocity
    import eov_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    eov_sample_if.sink   i_sample,
    eov_cfg_if.sink      i_cfg,
    eov_result_if.source o_result
);

    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int NUM_W   = 2 * RAW_W;          // dividend = |count| << 16
    localparam int DIV_CYC = NUM_W / 2;          // two quotient bits a cycle
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_CYC - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_POS  = 5'b00100,
        S_VEL  = 5'b01000,
        S_RST  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [RES_W-1:0] r_resolution;

    // architectural state
    logic [ANGLE_W-1:0] r_prev_angle;
    logic [POS_W-1:0]   r_pos;
    logic [VEL_W-1:0]   r_vel;
    logic [SLOT_W-1:0]  r_slot;

    // history ring: only the low 16 bits of each position are ever used
    logic [ANGLE_W-1:0]       r_hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hist_vld;
    logic [ANGLE_W-1:0]       r_rd_data;
    logic                     r_rd_vld;

    // divider
    logic [NUM_W-1:0]   r_num, n_num;
    logic [RES_W-1:0]   r_rem, n_rem;
    logic [ANGLE_W-1:0] r_quo, n_quo;
    logic [RES_W-1:0]   r_div;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [RES_W:0]     div_trial;

    // output register
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;
    logic signed [VEL_W-1:0] r_out_vel;

    logic               smp_xfer;
    logic               out_free;
    logic [SLOT_W-1:0]  slot_next;
    logic [RAW_W-1:0]   raw_mag;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] delta;
    logic [POS_W-1:0]   n_pos;
    logic [VEL_W-1:0]   hist_lo;
    logic [VEL_W-1:0]   diff;
    logic [VEL_W-1:0]   vsum;
    logic [VEL_W-1:0]   n_vel;

    assign i_cfg.ready      = 1'b1;
    assign i_sample.ready   = (r_state == S_IDLE);
    assign smp_xfer         = i_sample.valid && i_sample.ready;
    assign out_free         = !r_out_valid || o_result.ready;

    assign o_result.valid    = r_out_valid;
    assign o_result.position = r_out_pos;
    assign o_result.velocity = r_out_vel;

    assign slot_next = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;

    // |count| as unsigned; 0x8000 maps to 32768
    assign raw_mag = i_sample.raw_count[RAW_W-1]
                   ? RAW_W'(~i_sample.raw_count + 1'b1) : i_sample.raw_count;

    // restoring divider, two steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        n_quo = r_quo;
        div_trial = '0;
        for (int k = 0; k < 2; k++) begin
            div_trial = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (div_trial >= {1'b0, r_div}) begin
                n_rem = RES_W'(div_trial - {1'b0, r_div});
                n_quo = {n_quo[ANGLE_W-2:0], 1'b1};
            end else begin
                n_rem = div_trial[RES_W-1:0];
                n_quo = {n_quo[ANGLE_W-2:0], 1'b0};
            end
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign angle = r_neg ? ANGLE_W'(~r_quo + 1'b1) : r_quo;
    assign delta = angle - r_prev_angle;
    assign n_pos = r_pos + {{(POS_W-ANGLE_W){delta[ANGLE_W-1]}}, delta};

    // velocity filter; an unwritten history entry reads as zero
    assign hist_lo = r_rd_vld ? r_rd_data : '0;
    assign diff    = r_pos[VEL_W-1:0] - hist_lo;
    assign vsum    = r_vel + diff;
    assign n_vel   = VEL_W'($signed(vsum + {{(VEL_W-1){1'b0}}, vsum[VEL_W-1]}) >>> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (smp_xfer) begin
                    n_state = (i_sample.command == CMD_RESET) ? S_RST : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_POS;
                end
            end
            S_POS:   n_state = S_VEL;
            S_VEL:   if (out_free) n_state = S_IDLE;
            S_RST:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_resolution <= RES_RESET;
            r_prev_angle <= '0;
            r_pos        <= '0;
            r_vel        <= '0;
            r_slot       <= '0;
            r_hist_vld   <= '0;
            r_rd_vld     <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_resolution <= i_cfg.data;
            end
            // load from a final state, else drain on transfer
            if ((r_state == S_VEL || r_state == S_RST) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (smp_xfer) begin
                        if (i_sample.command == CMD_RESET) begin
                            r_prev_angle <= '0;
                            r_pos        <= '0;
                            r_vel        <= '0;
                            r_slot       <= '0;
                            r_hist_vld   <= '0;
                        end else begin
                            // oldest entry is the one after the write slot
                            r_rd_vld <= r_hist_vld[slot_next];
                        end
                    end
                end
                S_DIV: r_cnt <= r_cnt + 1'b1;
                S_POS: begin
                    r_prev_angle       <= angle;
                    r_pos              <= n_pos;
                    r_hist_vld[r_slot] <= 1'b1;
                    r_slot             <= slot_next;
                end
                S_VEL: begin
                    if (out_free) begin
                        r_vel <= n_vel;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (smp_xfer) begin
            r_num <= {raw_mag, {(NUM_W-RAW_W){1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_sample.raw_count[RAW_W-1];
            r_div <= (r_resolution == '0) ? RES_W'(1) : r_resolution;
        end else if (r_state == S_DIV) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (out_free && r_state == S_VEL) begin
            r_out_pos <= r_pos;
            r_out_vel <= n_vel;
        end else if (out_free && r_state == S_RST) begin
            r_out_pos <= '0;
            r_out_vel <= '0;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_POS) begin
            r_hist_mem[r_slot] <= n_pos[ANGLE_W-1:0];
        end
        if (smp_xfer) begin
            r_rd_data <= r_hist_mem[slot_next];
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("history slot out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_VEL || $past(r_state) == S_RST))
        else $error("result loaded outside a final state");

    a_sample_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (smp_xfer && i_sample.command == CMD_SAMPLE) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("sample transfer did not start the divider");

    a_div_to_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> ($past(r_state) == S_DIV && $past(r_cnt) == CNT_LAST))
        else $error("position update without a full division");

endmodule
